// ===== rtl/core/prc_pkg.sv =====
// Shared types, codes and helpers for the pump run controller.
package prc_pkg;

  // Item kinds carried in the func field
  localparam logic [1:0] FUNC_REPORT = 2'd0;
  localparam logic [1:0] FUNC_BUTTON = 2'd1;
  localparam logic [1:0] FUNC_TICK   = 2'd2;

  // Report codes and qualified tank states
  localparam logic [1:0] LEVEL_FULL   = 2'd0;
  localparam logic [1:0] LEVEL_EMPTY  = 2'd1;
  localparam logic [1:0] LEVEL_NODATA = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_NETWORK_MATCH_ID = 2'd0;
  localparam logic [1:0] REG_RUN_MINUTES      = 2'd1;
  localparam logic [1:0] REG_SILENCE_LIMIT    = 2'd2;
  localparam logic [1:0] REG_SEND_REPEATS     = 2'd3;

  localparam int unsigned TicksPerMinute  = 600;
  localparam int unsigned MinutesMax      = 18;
  localparam int unsigned MinutesFallback = 3;
  localparam int unsigned TimeLeftMax     = MinutesMax * TicksPerMinute;

  localparam logic [13:0] NETWORK_ID_RESET    = 14'd1033;
  localparam logic [4:0]  RUN_MINUTES_RESET   = 5'd3;
  localparam logic [7:0]  SILENCE_LIMIT_RESET = 8'd30;
  localparam logic [3:0]  SEND_REPEATS_RESET  = 4'd10;
  localparam logic [13:0] COUNTDOWN_RESET     = 14'(MinutesFallback * TicksPerMinute);

  localparam logic [1:0] REPORT_STREAK_MAX = 2'd3;
  localparam logic [1:0] START_STREAK      = 2'd3;
  localparam logic [1:0] NODATA_STREAK     = 2'd2;
  localparam logic [2:0] STOP_STREAK_MAX   = 3'd7;
  localparam logic [2:0] STOP_STREAK       = 3'd5;

  typedef struct packed {
    logic [1:0]  func;
    logic [13:0] report_network;
    logic [1:0]  report_level;
  } in_item_t;

  typedef struct packed {
    logic        motor_on;
    logic        send_now;
    logic        sent_code;
    logic [1:0]  tank_state;
    logic [13:0] time_left;
  } out_item_t;

  typedef struct packed {
    logic [13:0] network_match_id;
    logic [4:0]  run_minutes;
    logic [7:0]  silence_limit;
    logic [3:0]  send_repeats;
  } cfg_t;

  typedef struct packed {
    logic        motor_running;
    logic [1:0]  tank_level;
    logic [1:0]  full_streak;
    logic [1:0]  empty_streak;
    logic [1:0]  nodata_streak;
    logic [2:0]  stop_streak;
    logic [13:0] countdown;
    logic [7:0]  silence_ticks;
    logic        burst_active;
    logic [3:0]  burst_sent;
  } state_t;

  // Countdown reload; out-of-range minute settings fall back to the default
  function automatic logic [13:0] reload_value(input logic [4:0] minutes);
    logic [4:0] m;
    m = minutes;
    if (m == 5'd0 || m > 5'(MinutesMax)) begin
      m = 5'(MinutesFallback);
    end
    return 14'(m) * 14'(TicksPerMinute);
  endfunction

endpackage

// ===== rtl/core/prc_update.sv =====
// Next-state and result logic for one item of the pump run controller.
module prc_update (
  input  prc_pkg::state_t    state_i,
  input  prc_pkg::cfg_t      cfg_i,
  input  prc_pkg::in_item_t  item_i,
  output prc_pkg::state_t    state_o,
  output prc_pkg::out_item_t result_o
);

  always_comb begin
    prc_pkg::state_t s;
    logic            match;
    logic            sent;
    logic [13:0]     reload;

    s      = state_i;
    sent   = 1'b0;
    reload = prc_pkg::reload_value(cfg_i.run_minutes);
    match  = (item_i.report_network == cfg_i.network_match_id);

    case (item_i.func)
      prc_pkg::FUNC_REPORT: begin
        if (match && item_i.report_level == prc_pkg::LEVEL_FULL) begin
          if (s.full_streak != prc_pkg::REPORT_STREAK_MAX) begin
            s.full_streak = s.full_streak + 2'd1;
          end
          if (s.full_streak >= prc_pkg::START_STREAK && s.motor_running) begin
            s.motor_running = 1'b0;
            s.burst_active  = 1'b1;
            s.burst_sent    = 4'd0;
            s.countdown     = reload;
            s.full_streak   = 2'd0;
            s.tank_level    = prc_pkg::LEVEL_FULL;
          end
        end else begin
          s.full_streak = 2'd0;
        end

        if (match && item_i.report_level == prc_pkg::LEVEL_EMPTY) begin
          if (s.empty_streak != prc_pkg::REPORT_STREAK_MAX) begin
            s.empty_streak = s.empty_streak + 2'd1;
          end
          if (s.empty_streak >= prc_pkg::START_STREAK) begin
            s.motor_running = 1'b1;
            s.burst_active  = 1'b1;
            s.burst_sent    = 4'd0;
            s.empty_streak  = 2'd0;
            s.tank_level    = prc_pkg::LEVEL_EMPTY;
          end
        end else begin
          s.empty_streak = 2'd0;
        end

        if (match && item_i.report_level == prc_pkg::LEVEL_NODATA) begin
          if (s.nodata_streak != prc_pkg::REPORT_STREAK_MAX) begin
            s.nodata_streak = s.nodata_streak + 2'd1;
          end
          if (s.nodata_streak >= prc_pkg::NODATA_STREAK) begin
            s.nodata_streak = 2'd0;
            s.tank_level    = prc_pkg::LEVEL_NODATA;
          end
        end else begin
          s.nodata_streak = 2'd0;
        end

        s.silence_ticks = 8'd0;
      end

      prc_pkg::FUNC_BUTTON: begin
        if (!s.motor_running) begin
          s.motor_running = 1'b1;
          s.countdown     = reload;
        end else begin
          s.motor_running = 1'b0;
        end
        s.burst_active = 1'b1;
        s.burst_sent   = 4'd0;
      end

      prc_pkg::FUNC_TICK: begin
        if (s.motor_running) begin
          if (s.countdown != 14'd0) begin
            s.countdown = s.countdown - 14'd1;
          end
          if (s.countdown == 14'd0 || s.tank_level == prc_pkg::LEVEL_FULL) begin
            if (s.stop_streak != prc_pkg::STOP_STREAK_MAX) begin
              s.stop_streak = s.stop_streak + 3'd1;
            end
            if (s.stop_streak >= prc_pkg::STOP_STREAK) begin
              s.motor_running = 1'b0;
              s.burst_active  = 1'b1;
              s.burst_sent    = 4'd0;
              s.stop_streak   = 3'd0;
              s.countdown     = reload;
            end
          end else begin
            s.stop_streak = 3'd0;
          end
        end

        if (s.silence_ticks != 8'hFF) begin
          s.silence_ticks = s.silence_ticks + 8'd1;
        end
        if (s.silence_ticks > cfg_i.silence_limit &&
            s.tank_level != prc_pkg::LEVEL_NODATA) begin
          s.tank_level    = prc_pkg::LEVEL_NODATA;
          s.motor_running = 1'b0;
          s.burst_active  = 1'b1;
          s.burst_sent    = 4'd0;
          s.countdown     = reload;
        end

        // A send repeat of zero ends the burst after one send, like one
        if (s.burst_active) begin
          sent = 1'b1;
          if (s.burst_sent != 4'hF) begin
            s.burst_sent = s.burst_sent + 4'd1;
          end
          if (s.burst_sent >= cfg_i.send_repeats) begin
            s.burst_active = 1'b0;
          end
        end
      end

      default: begin
      end
    endcase

    state_o             = s;
    result_o.motor_on   = s.motor_running;
    result_o.send_now   = sent;
    result_o.sent_code  = sent & s.motor_running;
    result_o.tank_state = s.tank_level;
    result_o.time_left  = s.countdown;
  end

endmodule

// ===== rtl/core/pump_run_controller.sv =====
// Top level of the pump run controller: input stage, state, result register.
// Path: an input transfer is captured in the input stage, and its result is then loaded into the result register.
// Throughput: one item per cycle while the result register does not stall; the single state-update stage sets it.
// Backpressure: a full input stage holds while the result register stalls.
// Reset: asynchronous, active low; configuration returns to its defaults, the
// motor is off, the tank reads no data and a status burst is pending.
module pump_run_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  prc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output prc_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [13:0]        cfg_data_i
);

  prc_pkg::cfg_t      cfg_q;
  prc_pkg::state_t    state_q, state_d;
  prc_pkg::in_item_t  s1_item_q;
  logic               s1_valid_q;
  prc_pkg::out_item_t out_item_q, result;
  logic               out_valid_q;
  logic               advance;
  logic               in_xfer;

  // Advance when the result register is empty or its item transfers now
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  // Configuration writes: truncate data to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.network_match_id <= prc_pkg::NETWORK_ID_RESET;
      cfg_q.run_minutes      <= prc_pkg::RUN_MINUTES_RESET;
      cfg_q.silence_limit    <= prc_pkg::SILENCE_LIMIT_RESET;
      cfg_q.send_repeats     <= prc_pkg::SEND_REPEATS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prc_pkg::REG_NETWORK_MATCH_ID: cfg_q.network_match_id <= cfg_data_i;
        prc_pkg::REG_RUN_MINUTES:      cfg_q.run_minutes      <= cfg_data_i[4:0];
        prc_pkg::REG_SILENCE_LIMIT:    cfg_q.silence_limit    <= cfg_data_i[7:0];
        prc_pkg::REG_SEND_REPEATS:     cfg_q.send_repeats     <= cfg_data_i[3:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage: capture on transfer, drop once moved into the update stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_item_i;
    end
  end

  prc_update u_update (
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .item_i   (s1_item_q),
    .state_o  (state_d),
    .result_o (result)
  );

  // Commit state only when the held item moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.motor_running <= 1'b0;
      state_q.tank_level    <= prc_pkg::LEVEL_NODATA;
      state_q.full_streak   <= 2'd0;
      state_q.empty_streak  <= 2'd0;
      state_q.nodata_streak <= 2'd0;
      state_q.stop_streak   <= 3'd0;
      state_q.countdown     <= prc_pkg::COUNTDOWN_RESET;
      state_q.silence_ticks <= 8'd0;
      state_q.burst_active  <= 1'b1;
      state_q.burst_sent    <= 4'd0;
    end else if (advance && s1_valid_q) begin
      state_q <= state_d;
    end
  end

  // Result register: load on advance, clear valid when it drains empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ===== rtl/core/prc_checker.sv =====
// Port-level checks for the pump run controller, bound to the top level.
module prc_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input prc_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input prc_pkg::out_item_t out_item_o,
  input logic               cfg_we_i,
  input logic [1:0]         cfg_index_i,
  input logic [13:0]        cfg_data_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // Backpressure on input only when a result is waiting
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  a_code_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.send_now |-> !out_item_o.sent_code)
    else $error("status code without a send");

  a_code_motor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.send_now |-> out_item_o.sent_code == out_item_o.motor_on)
    else $error("status code disagrees with motor");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.time_left <= 14'(prc_pkg::TimeLeftMax))
    else $error("countdown beyond longest run");

endmodule

bind pump_run_controller prc_checker u_prc_checker (.*);

// ===== dv/tb_pump_run_controller.sv =====
// Self-checking testbench for the pump run controller: directed table, random phases, scoreboard.
module tb_pump_run_controller;

  // Codes the package leaves unnamed
  localparam logic [1:0] FUNC_IDLE   = 2'd3;  // unused item kind, changes nothing
  localparam logic [1:0] LEVEL_OTHER = 2'd3;  // report code that counts as no level

  localparam int CycleLimit  = 600000;
  localparam int DrainCycles = 8;

  // One stimulus row: the item, and a typed-in expectation where one is given
  typedef struct packed {
    prc_pkg::in_item_t  item;
    logic               typed;
    prc_pkg::out_item_t want;
  } stim_row_t;

  // Directed table. Rows with typed set carry a result read straight off the
  // reset state; all other rows are checked against the predictor.
  localparam stim_row_t DirTable [23] = '{
    // unused kind right after reset: state as reset, no transfer of status
    '{'{FUNC_IDLE,   14'd9999, LEVEL_OTHER}, 1'b1,
      '{1'b0, 1'b0, 1'b0, prc_pkg::LEVEL_NODATA, prc_pkg::COUNTDOWN_RESET}},
    // first tick sends the pending status burst, motor stopped
    '{'{prc_pkg::FUNC_TICK,   14'd0,    prc_pkg::LEVEL_FULL},  1'b1,
      '{1'b0, 1'b1, 1'b0, prc_pkg::LEVEL_NODATA, prc_pkg::COUNTDOWN_RESET}},
    // button start reloads the countdown
    '{'{prc_pkg::FUNC_BUTTON, 14'd0,    prc_pkg::LEVEL_FULL},  1'b1,
      '{1'b1, 1'b0, 1'b0, prc_pkg::LEVEL_NODATA, prc_pkg::COUNTDOWN_RESET}},
    '{'{prc_pkg::FUNC_TICK,   14'd16383, LEVEL_OTHER}, 1'b0, '0},
    // button stop keeps the countdown
    '{'{prc_pkg::FUNC_BUTTON, 14'd16383, LEVEL_OTHER}, 1'b0, '0},
    // wrong id breaks the empty streak
    '{'{prc_pkg::FUNC_REPORT, 14'd1032, prc_pkg::LEVEL_EMPTY}, 1'b0, '0},
    // three empty reports start the motor without a reload
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_EMPTY}, 1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_EMPTY}, 1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_EMPTY}, 1'b0, '0},
    '{'{prc_pkg::FUNC_TICK,   14'd0,    prc_pkg::LEVEL_FULL},  1'b0, '0},
    // three full reports stop a running motor
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_FULL},  1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_FULL},  1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_FULL},  1'b0, '0},
    // full while stopped: streak saturates, nothing else moves
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_FULL},  1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_FULL},  1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_FULL},  1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, LEVEL_OTHER}, 1'b0, '0},
    // two no-data reports qualify no data
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_NODATA}, 1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd1033, prc_pkg::LEVEL_NODATA}, 1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd0,    prc_pkg::LEVEL_NODATA}, 1'b0, '0},
    '{'{prc_pkg::FUNC_REPORT, 14'd9999, prc_pkg::LEVEL_FULL},  1'b0, '0},
    '{'{FUNC_IDLE,   14'd0,    prc_pkg::LEVEL_EMPTY}, 1'b0, '0},
    '{'{prc_pkg::FUNC_TICK,   14'd9999, prc_pkg::LEVEL_EMPTY}, 1'b0, '0}
  };

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic               in_ready_o;
  prc_pkg::in_item_t  in_item_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  prc_pkg::out_item_t out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = prc_pkg::REG_NETWORK_MATCH_ID;
  logic [13:0] cfg_data_i  = '0;

  pump_run_controller uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the controller: state and register settings
  prc_pkg::state_t pump_st;
  prc_pkg::cfg_t   pump_cfg;

  stim_row_t          stim_q [$];
  prc_pkg::out_item_t expected_status_q [$];
  stim_row_t          cur_row;

  int  errors     = 0;
  int  cycles     = 0;
  int  gap_left   = 0;
  int  stall_left = 0;
  bit  quiet      = 1'b0;  // set: no gaps and no stalls in this stretch

  // Mostly back to back, often a short gap, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [13:0] run_len_ticks(input logic [4:0] minutes);
    int unsigned m;
    m = minutes;
    if (m == 0 || m > prc_pkg::MinutesMax) m = prc_pkg::MinutesFallback;
    return 14'(m * prc_pkg::TicksPerMinute);
  endfunction

  task automatic rearm_status_burst();
    pump_st.burst_active = 1'b1;
    pump_st.burst_sent   = '0;
  endtask

  // Advance the shadow controller by one item and form its status result
  task automatic advance_pump(input prc_pkg::in_item_t it, output prc_pkg::out_item_t res);
    logic match;
    logic sent;
    sent  = 1'b0;
    match = (it.report_network == pump_cfg.network_match_id);
    case (it.func)
      prc_pkg::FUNC_REPORT: begin
        if (match && it.report_level == prc_pkg::LEVEL_FULL) begin
          if (pump_st.full_streak != prc_pkg::REPORT_STREAK_MAX)
            pump_st.full_streak = pump_st.full_streak + 2'd1;
          if (pump_st.full_streak >= prc_pkg::START_STREAK && pump_st.motor_running) begin
            pump_st.motor_running = 1'b0;
            rearm_status_burst();
            pump_st.countdown   = run_len_ticks(pump_cfg.run_minutes);
            pump_st.full_streak = '0;
            pump_st.tank_level  = prc_pkg::LEVEL_FULL;
          end
        end else begin
          pump_st.full_streak = '0;
        end
        if (match && it.report_level == prc_pkg::LEVEL_EMPTY) begin
          if (pump_st.empty_streak != prc_pkg::REPORT_STREAK_MAX)
            pump_st.empty_streak = pump_st.empty_streak + 2'd1;
          // empty start: countdown keeps its last value
          if (pump_st.empty_streak >= prc_pkg::START_STREAK) begin
            pump_st.motor_running = 1'b1;
            rearm_status_burst();
            pump_st.empty_streak = '0;
            pump_st.tank_level   = prc_pkg::LEVEL_EMPTY;
          end
        end else begin
          pump_st.empty_streak = '0;
        end
        if (match && it.report_level == prc_pkg::LEVEL_NODATA) begin
          if (pump_st.nodata_streak != prc_pkg::REPORT_STREAK_MAX)
            pump_st.nodata_streak = pump_st.nodata_streak + 2'd1;
          if (pump_st.nodata_streak >= prc_pkg::NODATA_STREAK) begin
            pump_st.nodata_streak = '0;
            pump_st.tank_level    = prc_pkg::LEVEL_NODATA;
          end
        end else begin
          pump_st.nodata_streak = '0;
        end
        // any report at all breaks the silence
        pump_st.silence_ticks = '0;
      end
      prc_pkg::FUNC_BUTTON: begin
        if (!pump_st.motor_running) begin
          pump_st.motor_running = 1'b1;
          pump_st.countdown     = run_len_ticks(pump_cfg.run_minutes);
        end else begin
          pump_st.motor_running = 1'b0;
        end
        rearm_status_burst();
      end
      prc_pkg::FUNC_TICK: begin
        if (pump_st.motor_running) begin
          if (pump_st.countdown != '0) pump_st.countdown = pump_st.countdown - 14'd1;
          if (pump_st.countdown == '0 || pump_st.tank_level == prc_pkg::LEVEL_FULL) begin
            if (pump_st.stop_streak != prc_pkg::STOP_STREAK_MAX)
              pump_st.stop_streak = pump_st.stop_streak + 3'd1;
            if (pump_st.stop_streak >= prc_pkg::STOP_STREAK) begin
              pump_st.motor_running = 1'b0;
              rearm_status_burst();
              pump_st.stop_streak = '0;
              pump_st.countdown   = run_len_ticks(pump_cfg.run_minutes);
            end
          end else begin
            pump_st.stop_streak = '0;
          end
        end
        if (pump_st.silence_ticks != 8'hFF)
          pump_st.silence_ticks = pump_st.silence_ticks + 8'd1;
        if (pump_st.silence_ticks > pump_cfg.silence_limit &&
            pump_st.tank_level != prc_pkg::LEVEL_NODATA) begin
          pump_st.tank_level    = prc_pkg::LEVEL_NODATA;
          pump_st.motor_running = 1'b0;
          rearm_status_burst();
          pump_st.countdown = run_len_ticks(pump_cfg.run_minutes);
        end
        if (pump_st.burst_active) begin
          sent = 1'b1;
          if (pump_st.burst_sent != 4'hF) pump_st.burst_sent = pump_st.burst_sent + 4'd1;
          if (pump_st.burst_sent >= pump_cfg.send_repeats) pump_st.burst_active = 1'b0;
        end
      end
      default: ;
    endcase
    res.motor_on   = pump_st.motor_running;
    res.send_now   = sent;
    res.sent_code  = sent & pump_st.motor_running;
    res.tank_state = pump_st.tank_level;
    res.time_left  = pump_st.countdown;
  endtask

  // Input side: hold an offered item until its transfer, then predict it
  always @(posedge clk_i) begin
    prc_pkg::out_item_t res;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_pump(cur_row.item, res);
        expected_status_q.push_back(cur_row.typed ? cur_row.want : res);
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (stim_q.size() != 0) begin
          cur_row = stim_q.pop_front();
          in_item_i  <= cur_row.item;
          in_valid_i <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Output side: compare each transfer with the oldest expectation, then
  // pick the next ready value
  always @(posedge clk_i) begin
    prc_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status_q.size() == 0) begin
        $error("status result with no expectation waiting");
        errors++;
      end else begin
        want = expected_status_q.pop_front();
        if (out_item_o.motor_on !== want.motor_on) begin
          $error("motor_on: expected %0d, actual %0d", want.motor_on, out_item_o.motor_on);
          errors++;
        end
        if (out_item_o.send_now !== want.send_now) begin
          $error("send_now: expected %0d, actual %0d", want.send_now, out_item_o.send_now);
          errors++;
        end
        if (out_item_o.sent_code !== want.sent_code) begin
          $error("sent_code: expected %0d, actual %0d", want.sent_code, out_item_o.sent_code);
          errors++;
        end
        if (out_item_o.tank_state !== want.tank_state) begin
          $error("tank_state: expected %0d, actual %0d", want.tank_state,
                 out_item_o.tank_state);
          errors++;
        end
        if (out_item_o.time_left !== want.time_left) begin
          $error("time_left: expected %0d, actual %0d", want.time_left, out_item_o.time_left);
          errors++;
        end
      end
    end
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      stall_left = pick_gap();
      out_ready_i <= (stall_left == 0);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic [1:0] func, input logic [13:0] net,
                           input logic [1:0] lvl);
    stim_row_t row;
    row.item  = '{func, net, lvl};
    row.typed = 1'b0;
    row.want  = '0;
    stim_q.push_back(row);
  endtask

  // Block until nothing is queued, offered or in flight; sample mid-cycle so
  // the edge's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (stim_q.size() != 0 || in_valid_i || expected_status_q.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [13:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    case (idx)
      prc_pkg::REG_NETWORK_MATCH_ID: pump_cfg.network_match_id = val[13:0];
      prc_pkg::REG_RUN_MINUTES:      pump_cfg.run_minutes      = val[4:0];
      prc_pkg::REG_SILENCE_LIMIT:    pump_cfg.silence_limit    = val[7:0];
      prc_pkg::REG_SEND_REPEATS:     pump_cfg.send_repeats     = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // Reprogram every register once the controller is idle
  task automatic write_cfg(input int unsigned id, input int unsigned mins,
                           input int unsigned sil, input int unsigned reps);
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    write_reg(prc_pkg::REG_NETWORK_MATCH_ID, 14'(id));
    write_reg(prc_pkg::REG_RUN_MINUTES, 14'(mins));
    write_reg(prc_pkg::REG_SILENCE_LIMIT, 14'(sil));
    write_reg(prc_pkg::REG_SEND_REPEATS, 14'(reps));
    cfg_we_i <= 1'b0;
  endtask

  // Random phase: mostly well-formed report streaks and tick runs, the rest
  // noise, broken streaks and button presses
  task automatic run_random(input int n);
    int made;
    int r;
    int len;
    logic [13:0] id;
    logic [1:0]  lvl;
    made = 0;
    while (made < n) begin
      r   = $urandom_range(0, 99);
      id  = pump_cfg.network_match_id;
      lvl = 2'($urandom_range(0, 2));
      if (r < 30) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        repeat (len)
          push_item(prc_pkg::FUNC_TICK, 14'($urandom_range(0, 9999)),
                    2'($urandom_range(0, 3)));
        made += len;
      end else if (r < 55) begin
        repeat (3) push_item(prc_pkg::FUNC_REPORT, id, lvl);
        made += 3;
      end else if (r < 62) begin
        repeat (2) push_item(prc_pkg::FUNC_REPORT, id, prc_pkg::LEVEL_NODATA);
        made += 2;
      end else if (r < 72) begin
        push_item(prc_pkg::FUNC_BUTTON, 14'($urandom_range(0, 9999)),
                  2'($urandom_range(0, 3)));
        made++;
      end else if (r < 82) begin
        push_item(prc_pkg::FUNC_REPORT,
                  ($urandom_range(0, 3) == 0) ? id : 14'($urandom_range(0, 9999)),
                  2'($urandom_range(0, 3)));
        made++;
      end else if (r < 88) begin
        // broken streak: one or two good reports, then a wrong id or other code
        len = $urandom_range(1, 2);
        repeat (len) push_item(prc_pkg::FUNC_REPORT, id, lvl);
        if ($urandom_range(0, 1) == 1)
          push_item(prc_pkg::FUNC_REPORT, (id == 14'd9999) ? 14'd0 : id + 14'd1, lvl);
        else
          push_item(prc_pkg::FUNC_REPORT, id, LEVEL_OTHER);
        made += len + 1;
      end else if (r < 92) begin
        push_item(FUNC_IDLE, 14'($urandom_range(0, 9999)), 2'($urandom_range(0, 3)));
        made++;
      end else if (r < 97) begin
        // long enough without reports to trip a silence limit below 60; 12 ticks otherwise
        len = (pump_cfg.silence_limit < 60) ? pump_cfg.silence_limit + 2 : 12;
        repeat (len)
          push_item(prc_pkg::FUNC_TICK, 14'($urandom_range(0, 9999)),
                    prc_pkg::LEVEL_FULL);
        made += len;
      end else begin
        // hold the sender until every result is back
        wait_idle();
      end
    end
  endtask

  initial begin
    pump_cfg = '{prc_pkg::NETWORK_ID_RESET, prc_pkg::RUN_MINUTES_RESET,
                 prc_pkg::SILENCE_LIMIT_RESET, prc_pkg::SEND_REPEATS_RESET};
    pump_st  = '0;
    pump_st.tank_level   = prc_pkg::LEVEL_NODATA;
    pump_st.countdown    = prc_pkg::COUNTDOWN_RESET;
    pump_st.burst_active = 1'b1;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings
    for (int i = 0; i < $size(DirTable); i++) stim_q.push_back(DirTable[i]);

    // Low extremes, no idling at all
    write_cfg(0, 1, 1, 1);
    quiet = 1'b1;
    run_random(120);

    // High extremes
    write_cfg(9999, 18, 255, 15);
    quiet = 1'b0;
    run_random(120);

    // Run length out of range falls back; a repeat count of zero ends each burst after one send
    write_cfg(1033, 0, 5, 0);
    run_random(120);
    write_cfg($urandom_range(0, 9999), 31, 10, 3);
    run_random(120);
    write_cfg($urandom_range(0, 9999), 2, 20, 7);
    run_random(120);

    // Countdown expiry: no data held, silence disabled, run one minute out
    write_cfg(5000, 1, 255, 2);
    repeat (2) push_item(prc_pkg::FUNC_REPORT, 14'd5000, prc_pkg::LEVEL_NODATA);
    wait_idle();
    if (pump_st.motor_running) push_item(prc_pkg::FUNC_BUTTON, 14'd0, prc_pkg::LEVEL_FULL);
    push_item(prc_pkg::FUNC_BUTTON, 14'd0, prc_pkg::LEVEL_FULL);
    repeat (prc_pkg::TicksPerMinute + 10)
      push_item(prc_pkg::FUNC_TICK, 14'd0, prc_pkg::LEVEL_FULL);
    run_random(100);

    write_cfg($urandom_range(0, 9999), $urandom_range(1, 18), $urandom_range(1, 255),
              $urandom_range(1, 15));
    run_random(150);

    // Back to the reset settings
    write_cfg(prc_pkg::NETWORK_ID_RESET, prc_pkg::RUN_MINUTES_RESET,
              prc_pkg::SILENCE_LIMIT_RESET, prc_pkg::SEND_REPEATS_RESET);
    run_random(120);

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/prc_pkg.sv
rtl/core/prc_update.sv
rtl/core/pump_run_controller.sv
rtl/core/prc_checker.sv
dv/tb_pump_run_controller.sv
